>>> rtl/core/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package utd_pkg;

    // Byte class masks.
    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hC0;
    localparam logic [7:0] CONT_MASK  = 8'h80;

    // Payload masks for the parts of a sequence.
    localparam logic [7:0] CONT_BITS  = 8'h3F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;

    // Replacement character '?'.
    localparam logic [15:0] REPL_UNIT = 16'd63;

    // Most results that one input byte can cause.
    localparam int MAX_RES = 3;

    // Stream widths: tdata is padded to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Error kinds reported beside each code unit.
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TRUNC    = 2'd1,
        ERR_BAD_CONT = 2'd2,
        ERR_STRAY    = 2'd3
    } t_err_kind;

    // Bytes of an incomplete sequence carried between input beats.
    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] held;
        logic [1:0] pend;
    } t_dec_state;

    // Everything one input byte produces.
    typedef struct packed {
        logic [MAX_RES-1:0][15:0] unit;
        logic [MAX_RES-1:0][1:0]  kind;
        logic [MAX_RES-1:0]       last;
        logic [MAX_RES-1:0]       done;
        logic [1:0]               cnt;
        logic                     halt;
        t_dec_state               nxt;
    } t_dec_out;

endpackage

>>> rtl/core/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 decoder top level: input register, decode state and result register.
// Each byte passes from the input register through the combinational decode into the
// result register, which offers its first code unit. Throughput: one byte per cycle
// while each byte yields at most one code unit and the output is ready; a byte that
// yields two or three units holds the next byte until its last unit is taken.
// Reset (synchronous, active low) clears held bytes, the halt flag and error_mode.
module utf8_to_utf16_decoder_core (
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration write: error_mode [0]
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data,
    // Input stream; tdata: in_byte [7:0]; tlast: end_of_text
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [utd_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    // Output stream; tdata: code_unit [15:0], error_kind [17:16], zero pad [23:18]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [utd_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // tlast: last_of_run; tuser: string_done [0]
    output logic                              o_m_axis_tlast,
    output logic                              o_m_axis_tuser
);
    import utd_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_mode;
    logic       r_halted;
    t_dec_state r_state;
    t_dec_out   dec;
    logic       buf_free;
    logic       consume;
    logic       load;

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    // A byte leaves the input register when its results fit, or is dropped when halted.
    assign load            = r_in_vld && buf_free && !r_halted;
    assign consume         = r_in_vld && (buf_free || r_halted);
    assign o_s_axis_tready = !r_in_vld || consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    // Mode register and decode state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_halted <= 1'b0;
            r_state  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (load) begin
                r_state  <= dec.nxt;
                r_halted <= dec.halt;
            end
        end
    end

    utd_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_mode  (r_mode),
        .o_res   (dec)
    );

    utd_res_buf u_res_buf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_res           (dec),
        .o_free          (buf_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

>>> rtl/core/utd_decode.sv
// Combinational decode of the held bytes plus one new byte into up to three code units.
module utd_decode (
    input  utd_pkg::t_dec_state i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    input  logic                i_mode,
    output utd_pkg::t_dec_out   o_res
);
    import utd_pkg::*;

    // Byte at a position of the work buffer, zero past its end.
    function automatic logic [7:0] byte_at(input logic [2:0][7:0] bytes, input logic [2:0] idx);
        logic [7:0] v;
        v = 8'd0;
        if (idx < 3'd3) begin
            v = bytes[idx[1:0]];
        end
        return v;
    endfunction

    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic [2:0]      p;
    logic [1:0]      cnt;
    logic            stop;
    logic [7:0]      b;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [2:0]      need;
    logic [2:0]      avail;
    logic            bad;
    logic            fail;
    t_err_kind       err;

    always_comb begin
        o_res = '0;
        bytes = '0;
        n     = 2'd0;
        p     = 3'd0;
        cnt   = 2'd0;
        stop  = 1'b0;
        b     = 8'd0;
        b1    = 8'd0;
        b2    = 8'd0;
        need  = 3'd0;
        avail = 3'd0;
        bad   = 1'b0;
        fail  = 1'b0;
        err   = ERR_NONE;

        // Gather held bytes ahead of the new one.
        if (i_state.pend >= 2'd1) begin
            bytes[0] = i_state.lead;
            n        = 2'd1;
        end
        if (i_state.pend >= 2'd2) begin
            bytes[1] = i_state.held;
            n        = 2'd2;
        end
        bytes[n] = i_byte;
        n        = n + 2'd1;

        // Each pass resolves at least one byte, so three passes cover the buffer.
        for (int i = 0; i < MAX_RES; i++) begin
            if (!stop && p < {1'b0, n}) begin
                b     = byte_at(bytes, p);
                b1    = byte_at(bytes, p + 3'd1);
                b2    = byte_at(bytes, p + 3'd2);
                avail = {1'b0, n} - p;
                fail  = 1'b0;
                err   = ERR_NONE;

                if ((b & LEAD3_MASK) == LEAD3_MASK) begin
                    need = 3'd3;
                end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
                    need = 3'd2;
                end else if ((b & CONT_MASK) == 8'd0) begin
                    need = 3'd1;
                end else begin
                    need = 3'd0;
                end

                // A present follower without its top bit breaks the sequence.
                bad = (avail > 3'd1 && (b1 & CONT_MASK) == 8'd0)
                    || (need == 3'd3 && avail > 3'd2 && (b2 & CONT_MASK) == 8'd0);

                if (need == 3'd1) begin
                    o_res.unit[cnt] = {8'd0, b};
                    o_res.kind[cnt] = ERR_NONE;
                    cnt             = cnt + 2'd1;
                    p               = p + 3'd1;
                end else if (need == 3'd0) begin
                    fail = 1'b1;
                    err  = ERR_STRAY;
                end else if (avail < need) begin
                    if (i_end) begin
                        fail = 1'b1;
                        err  = ERR_TRUNC;
                    end else if (bad) begin
                        fail = 1'b1;
                        err  = ERR_BAD_CONT;
                    end else begin
                        // Sequence not complete yet: keep it for the next beat.
                        o_res.nxt.lead = b;
                        o_res.nxt.held = (avail == 3'd2) ? b1 : 8'd0;
                        o_res.nxt.pend = avail[1:0];
                        stop           = 1'b1;
                    end
                end else if (bad) begin
                    fail = 1'b1;
                    err  = ERR_BAD_CONT;
                end else begin
                    if (need == 3'd3) begin
                        o_res.unit[cnt] = {(b[3:0] & LEAD3_BITS[3:0]),
                                           (b1[5:0] & CONT_BITS[5:0]),
                                           (b2[5:0] & CONT_BITS[5:0])};
                    end else begin
                        o_res.unit[cnt] = {2'd0, (b & LEAD2_BITS), 6'd0}
                                        | {8'd0, (b1 & CONT_BITS)};
                    end
                    o_res.kind[cnt] = ERR_NONE;
                    cnt             = cnt + 2'd1;
                    p               = p + need;
                end

                // Failed lead: replace it and restart at the byte after it, or halt in error mode.
                if (fail) begin
                    o_res.unit[cnt] = REPL_UNIT;
                    o_res.kind[cnt] = err;
                    cnt             = cnt + 2'd1;
                    p               = p + 3'd1;
                    if (i_mode) begin
                        o_res.halt = 1'b1;
                        stop       = 1'b1;
                    end
                end
            end
        end

        // Halting drops anything still held.
        if (o_res.halt) begin
            o_res.nxt = '0;
        end

        // Mark the final result of this byte and, where it applies, of the string.
        o_res.cnt = cnt;
        if (cnt != 2'd0) begin
            o_res.last[cnt - 2'd1] = 1'b1;
            o_res.done[cnt - 2'd1] = i_end || o_res.halt;
        end
    end

endmodule

>>> rtl/core/utd_res_buf.sv
// Result register holding up to three code units, drained one beat at a time.
module utd_res_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  utd_pkg::t_dec_out   i_res,
    output logic                o_free,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata: code_unit [15:0], error_kind [17:16], zero pad [23:18]
    output logic [utd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast,
    // tuser: string_done [0]
    output logic                o_m_axis_tuser
);
    import utd_pkg::*;

    logic [MAX_RES-1:0][15:0] r_unit, n_unit;
    logic [MAX_RES-1:0][1:0]  r_kind, n_kind;
    logic [MAX_RES-1:0]       r_last, n_last;
    logic [MAX_RES-1:0]       r_done, n_done;
    logic [1:0]               r_cnt, n_cnt;
    logic                     beat;

    assign beat   = (r_cnt != 2'd0) && i_m_axis_tready;
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && beat);

    // Load a fresh set of results, or shift the next one to the head after a beat.
    always_comb begin
        n_unit = r_unit;
        n_kind = r_kind;
        n_last = r_last;
        n_done = r_done;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_unit = i_res.unit;
            n_kind = i_res.kind;
            n_last = i_res.last;
            n_done = i_res.done;
            n_cnt  = i_res.cnt;
        end else if (beat) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                n_unit[i] = r_unit[i + 1];
                n_kind[i] = r_kind[i + 1];
                n_last[i] = r_last[i + 1];
                n_done[i] = r_done[i + 1];
            end
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Count is control state; the entries are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
        r_kind <= n_kind;
        r_last <= n_last;
        r_done <= n_done;
    end

    // The head entry drives the output stream.
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 18){1'b0}}, r_kind[0], r_unit[0]};
    assign o_m_axis_tlast  = r_last[0];
    assign o_m_axis_tuser  = r_done[0];

endmodule
